FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, types and pointer helpers for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // queue geometry
  localparam int DEPTH     = 16;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // port field widths
  localparam int PRIO_W    = 8;
  localparam int PAYLOAD_W = 32;
  localparam int COUNT_W   = 5;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // one stored entry
  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [DATA_BITS-1:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result item handed from the core to the output stage
  typedef struct packed {
    logic                 removed_valid;
    logic [PRIO_W-1:0]    removed_priority;
    logic [PAYLOAD_W-1:0] removed_payload;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;
    logic                 overflow;
  } res_t;

  // circular pointer step forward
  function automatic idx_t ptr_inc(input idx_t p);
    idx_t r;
    if (p == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + IDX_W'(1);
    end
    return r;
  endfunction

  // circular pointer step back
  function automatic idx_t ptr_dec(input idx_t p);
    idx_t r;
    if (p == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = p - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: design/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/spq_core.sv
// ----------------------------------------------------------------------------
// spq_core
// Queue engine: circular sorted store in RAM, insert walks back from the tail
// shifting lower-priority entries one slot per cycle, remove reads the head.
// ----------------------------------------------------------------------------
module spq_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [spq_pkg::PRIO_W-1:0]       in_priority_req,
  input  logic [spq_pkg::PAYLOAD_W-1:0]    in_payload,
  output logic                             res_pend,
  output spq_pkg::res_t                    res,
  input  logic                             res_take
);

  import spq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HEAD  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_PLACE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  idx_t                    head_r, head_nxt;
  idx_t                    tail_r, tail_nxt;
  cnt_t                    count_r, count_nxt;
  idx_t                    wr_ptr_r, wr_ptr_nxt;
  cnt_t                    left_r, left_nxt;
  entry_t                  new_r, new_nxt;
  logic                    res_pend_r, res_pend_nxt;
  res_t                    res_r, res_nxt;
  logic                    res_load;

  logic                    accept;
  entry_t                  in_entry;
  entry_t                  rd_entry;
  logic [ENTRY_W-1:0]      rd_data;
  logic                    ram_we;
  idx_t                    ram_waddr;
  entry_t                  ram_wdata;
  idx_t                    ram_raddr;

  // entry store
  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign rd_entry       = entry_t'(rd_data);
  assign in_entry.prio  = in_priority_req;
  assign in_entry.data  = DATA_BITS'(in_payload);

  // one item at a time, and only while the result slot is free or being emptied
  assign in_stall = !((state_r == S_IDLE) && (!res_pend_r || res_take));
  assign accept   = in_valid && !in_stall;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    wr_ptr_nxt = wr_ptr_r;
    left_nxt   = left_r;
    new_nxt    = new_r;
    res_nxt    = res_r;
    res_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wr_ptr_r;
    ram_wdata  = new_r;
    ram_raddr  = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_nxt                  = in_entry;
          res_nxt.removed_valid    = 1'b0;
          res_nxt.removed_priority = '0;
          res_nxt.removed_payload  = '0;
          res_nxt.overflow         = 1'b0;
          res_nxt.entry_count      = COUNT_W'(count_r);
          res_nxt.is_empty         = (count_r == '0);
          if (in_kind == KIND_REMOVE) begin
            if (count_r == '0) begin
              // remove on empty queue: no change
              res_load = 1'b1;
            end else begin
              ram_raddr = head_r;
              state_nxt = S_HEAD;
            end
          end else begin
            if (count_r == CNT_W'(DEPTH)) begin
              // full queue: item dropped
              res_nxt.overflow = 1'b1;
              res_load         = 1'b1;
            end else if (count_r == '0) begin
              // first entry goes straight in
              ram_we              = 1'b1;
              ram_waddr           = tail_r;
              ram_wdata           = in_entry;
              tail_nxt            = ptr_inc(tail_r);
              count_nxt           = count_r + CNT_W'(1);
              res_nxt.entry_count = COUNT_W'(count_r + CNT_W'(1));
              res_nxt.is_empty    = 1'b0;
              res_load            = 1'b1;
            end else begin
              // start the walk at the last stored entry
              ram_raddr  = ptr_dec(tail_r);
              wr_ptr_nxt = tail_r;
              left_nxt   = count_r;
              state_nxt  = S_SCAN;
            end
          end
        end
      end

      S_HEAD: begin
        res_nxt.removed_valid    = 1'b1;
        res_nxt.removed_priority = rd_entry.prio;
        res_nxt.removed_payload  = PAYLOAD_W'(rd_entry.data);
        res_nxt.entry_count      = COUNT_W'(count_r - CNT_W'(1));
        res_nxt.is_empty         = (count_r == CNT_W'(1));
        res_load                 = 1'b1;
        head_nxt                 = ptr_inc(head_r);
        count_nxt                = count_r - CNT_W'(1);
        state_nxt                = S_IDLE;
      end

      S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_r;
        if (rd_entry.prio < new_r.prio) begin
          // lower priority moves one slot toward the tail
          ram_wdata  = rd_entry;
          wr_ptr_nxt = ptr_dec(wr_ptr_r);
          left_nxt   = left_r - CNT_W'(1);
          ram_raddr  = ptr_dec(ptr_dec(wr_ptr_r));
          if (left_r == CNT_W'(1)) begin
            state_nxt = S_PLACE;
          end
        end else begin
          // new entry lands behind equal or higher priority
          ram_wdata           = new_r;
          tail_nxt            = ptr_inc(tail_r);
          count_nxt           = count_r + CNT_W'(1);
          res_nxt.entry_count = COUNT_W'(count_r + CNT_W'(1));
          res_nxt.is_empty    = 1'b0;
          res_load            = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      S_PLACE: begin
        // new entry becomes the head
        ram_we              = 1'b1;
        ram_waddr           = wr_ptr_r;
        ram_wdata           = new_r;
        tail_nxt            = ptr_inc(tail_r);
        count_nxt           = count_r + CNT_W'(1);
        res_nxt.entry_count = COUNT_W'(count_r + CNT_W'(1));
        res_nxt.is_empty    = 1'b0;
        res_load            = 1'b1;
        state_nxt           = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result slot occupancy
  always_comb begin
    res_pend_nxt = res_pend_r;
    if (res_take) begin
      res_pend_nxt = 1'b0;
    end
    if (res_load) begin
      res_pend_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      res_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      res_pend_r <= res_pend_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    wr_ptr_r <= wr_ptr_nxt;
    left_r   <= left_nxt;
    new_r    <= new_nxt;
    res_r    <= res_nxt;
  end

  assign res_pend = res_pend_r;
  assign res      = res_r;

endmodule

FILE: design/sorted_priority_queue.sv
// Sorted priority queue, up to 16 entries in one RAM kept as a circular sorted list.
// Remove: the head is read, then the result goes via the result slot to the output register.
// Insert: the walk moves one entry per cycle through the single RAM read port and write port.
// Full, empty and first insert need no walk; their result goes straight to the result slot.
// One item in flight; the next is taken once the previous one has finished.
// Reset clears count, pointers and handshake state; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Top level: queue engine plus the output register of the result channel.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [spq_pkg::PRIO_W-1:0]       in_priority_req,
  input  logic [spq_pkg::PAYLOAD_W-1:0]    in_payload,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_removed_valid,
  output logic [spq_pkg::PRIO_W-1:0]       out_removed_priority,
  output logic [spq_pkg::PAYLOAD_W-1:0]    out_removed_payload,
  output logic [spq_pkg::COUNT_W-1:0]      out_entry_count,
  output logic                             out_is_empty,
  output logic                             out_overflow
);

  import spq_pkg::*;

  logic res_pend;
  res_t res;
  logic res_take;
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  // queue engine
  spq_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .res_pend        (res_pend),
    .res             (res),
    .res_take        (res_take)
  );

  // move a result item into the output register when it is free or draining
  assign res_take = res_pend && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  // result ports
  assign out_valid            = out_valid_r;
  assign out_removed_valid    = out_r.removed_valid;
  assign out_removed_priority = out_r.removed_priority;
  assign out_removed_payload  = out_r.removed_payload;
  assign out_entry_count      = out_r.entry_count;
  assign out_is_empty         = out_r.is_empty;
  assign out_overflow         = out_r.overflow;

endmodule

FILE: test/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the sorted priority queue. It keeps its own sorted
// copy of the queue, works out the result of every accepted item and compares
// each returned result, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module spq_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_kind,
  input  logic [spq_pkg::PRIO_W-1:0]    in_priority_req,
  input  logic [spq_pkg::PAYLOAD_W-1:0] in_payload,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_removed_valid,
  input  logic [spq_pkg::PRIO_W-1:0]    out_removed_priority,
  input  logic [spq_pkg::PAYLOAD_W-1:0] out_removed_payload,
  input  logic [spq_pkg::COUNT_W-1:0]   out_entry_count,
  input  logic                          out_is_empty,
  input  logic                          out_overflow,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // sorted copy of the queue, slot 0 is the head
  logic [PRIO_W-1:0]    slot_prio [DEPTH];
  logic [DATA_BITS-1:0] slot_data [DEPTH];
  int                   held = 0;
  int                   errs = 0;
  res_t                 awaited_q [$];

  // apply one item to the queue copy and return the result it causes
  function automatic res_t queue_step(input logic kind, input logic [PRIO_W-1:0] prio,
                                      input logic [PAYLOAD_W-1:0] data);
    res_t r;
    int   pos;
    int   i;
    r = '0;
    if (kind == KIND_INSERT) begin
      if (held >= DEPTH) begin
        // full queue drops the entry
        r.overflow = 1'b1;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < held && slot_prio[pos] >= prio) pos++;
        for (i = held; i > pos; i--) begin
          slot_prio[i] = slot_prio[i-1];
          slot_data[i] = slot_data[i-1];
        end
        slot_prio[pos] = prio;
        slot_data[pos] = data[DATA_BITS-1:0];
        held++;
      end
    end else if (held > 0) begin
      // take the head and close the gap
      r.removed_valid    = 1'b1;
      r.removed_priority = slot_prio[0];
      r.removed_payload  = PAYLOAD_W'(slot_data[0]);
      for (i = 1; i < held; i++) begin
        slot_prio[i-1] = slot_prio[i];
        slot_data[i-1] = slot_data[i];
      end
      held--;
    end
    r.entry_count = COUNT_W'(held);
    r.is_empty    = (held == 0);
    return r;
  endfunction

  // compare one field and count a mismatch
  task automatic check_field(input string label, input logic [63:0] want,
                             input logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, seen);
      errs++;
    end
  endtask

  // results are checked before the item of the same edge is predicted
  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      held = 0;
      awaited_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          $display("%0t ns: result with none expected, expected nothing, actual %0h",
                   $time, {out_removed_valid, out_removed_priority, out_removed_payload,
                           out_entry_count, out_is_empty, out_overflow});
          errs++;
        end else begin
          want = awaited_q.pop_front();
          check_field("removed_valid", 64'(want.removed_valid), 64'(out_removed_valid));
          check_field("removed_priority", 64'(want.removed_priority),
                      64'(out_removed_priority));
          check_field("removed_payload", 64'(want.removed_payload),
                      64'(out_removed_payload));
          check_field("entry_count", 64'(want.entry_count), 64'(out_entry_count));
          check_field("is_empty", 64'(want.is_empty), 64'(out_is_empty));
          check_field("overflow", 64'(want.overflow), 64'(out_overflow));
        end
      end
      if (in_valid && !in_stall) begin
        awaited_q.push_back(queue_step(in_kind, in_priority_req, in_payload));
      end
    end
    fail_count    <= errs;
    pending_count <= awaited_q.size();
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the sorted priority queue with a short directed sequence (empty
// remove, extremes, equal priorities, fill and overflow) and then with random
// runs that lean toward filling, draining or mixing, under random stalls on
// both sides. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int ITEM_TOTAL  = 1550;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 200;

  // leaning of a random run and spread of its priorities
  typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;
  typedef enum int {PRIO_ANY, PRIO_FEW, PRIO_EDGE} spread_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_kind = KIND_INSERT;
  logic [PRIO_W-1:0]    in_priority_req = '0;
  logic [PAYLOAD_W-1:0] in_payload = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  logic                 out_removed_valid;
  logic [PRIO_W-1:0]    out_removed_priority;
  logic [PAYLOAD_W-1:0] out_removed_payload;
  logic [COUNT_W-1:0]   out_entry_count;
  logic                 out_is_empty;
  logic                 out_overflow;
  int                   fail_count;
  int                   pending_count;
  int                   quiet = 0;
  logic                 send_calm = 1'b0;
  logic                 recv_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_priority_queue dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_priority_req      (in_priority_req),
    .in_payload           (in_payload),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_removed_valid    (out_removed_valid),
    .out_removed_priority (out_removed_priority),
    .out_removed_payload  (out_removed_payload),
    .out_entry_count      (out_entry_count),
    .out_is_empty         (out_is_empty),
    .out_overflow         (out_overflow)
  );

  spq_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_priority_req      (in_priority_req),
    .in_payload           (in_payload),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_removed_valid    (out_removed_valid),
    .out_removed_priority (out_removed_priority),
    .out_removed_payload  (out_removed_payload),
    .out_entry_count      (out_entry_count),
    .out_is_empty         (out_is_empty),
    .out_overflow         (out_overflow),
    .fail_count           (fail_count),
    .pending_count        (pending_count)
  );

  // offer one item after a random gap and wait until it is taken
  task automatic send_item(input logic kind, input logic [PRIO_W-1:0] prio,
                           input logic [PAYLOAD_W-1:0] data);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_priority_req <= prio;
    in_payload      <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result side: random stalls, calm stretches and two long hold-offs
  initial begin : drain
    int hold;
    int got;
    got = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (got % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      if (got == 300 || got == 1000) begin
        hold = LONG_HOLD;
      end else begin
        hold = recv_calm ? 0 : $urandom_range(0, 14);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got++;
    end
  end

  // reset, directed items, random runs, then the verdict
  initial begin : stimulus
    int      sent;
    int      run_len;
    int      insert_pct;
    lean_t   lean;
    spread_t spread;
    logic    kind;
    logic [PRIO_W-1:0] prio;
    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // remove on an empty queue
    send_item(KIND_REMOVE, 8'hff, 32'hffff_ffff);
    // extremes, and two equal priorities that must leave in arrival order
    send_item(KIND_INSERT, 8'h00, 32'h0000_0000);
    send_item(KIND_INSERT, 8'hff, 32'hffff_ffff);
    send_item(KIND_INSERT, 8'hff, 32'h1234_5678);
    send_item(KIND_INSERT, 8'h80, 32'h8000_0001);
    send_item(KIND_REMOVE, 8'h00, 32'h0);
    send_item(KIND_REMOVE, 8'h00, 32'h0);
    sent = 7;
    // fill to the top with mixed and repeated priorities
    for (int i = 0; i < 14; i++) begin
      send_item(KIND_INSERT, PRIO_W'((i * 37) % 5 * 51), PAYLOAD_W'(32'ha5a5_0000 + i));
      sent++;
    end
    // inserts into a full queue are dropped
    send_item(KIND_INSERT, 8'hff, 32'hdead_beef);
    send_item(KIND_INSERT, 8'h00, 32'h5555_aaaa);
    sent += 2;

    // random runs leaning toward fill, drain or a mix
    while (sent < ITEM_TOTAL) begin
      send_calm  = ($urandom_range(0, 3) == 0);
      lean       = lean_t'($urandom_range(0, 2));
      spread     = spread_t'($urandom_range(0, 2));
      run_len    = $urandom_range(10, 50);
      case (lean)
        LEAN_FILL:  insert_pct = 85;
        LEAN_DRAIN: insert_pct = 15;
        default:    insert_pct = 50;
      endcase
      repeat (run_len) begin
        kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
        case (spread)
          PRIO_FEW:  prio = PRIO_W'($urandom_range(0, 3));
          PRIO_EDGE: prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
          default:   prio = PRIO_W'($urandom_range(0, 255));
        endcase
        send_item(kind, prio, $urandom());
        sent++;
      end
    end
    in_valid <= 1'b0;

    // let every result come back, then allow for a stray one
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/spq_pkg.sv
design/spq_ram.sv
design/spq_core.sv
design/sorted_priority_queue.sv
test/spq_checker.sv
test/tb_top.sv
